FILE: hdl/hdcf_pkg.sv
// hdcf_pkg: shared types, widths and constants for the halftone dot cell filter
// used by the interfaces, the controller, the datapath and the top level
// no dependencies
package hdcf_pkg;

  localparam int CS_W     = 7;   // cell_size register width
  localparam int COORD_W  = 6;   // row/column inside a cell
  localparam int PIX_W    = 8;
  localparam int SUM_W    = 20;
  localparam int TONE_W   = 4;
  localparam int CNT_W    = 4;

  localparam int MAX_CELL_SIZE_DEF = 64;

  localparam logic [CS_W-1:0]   CS_RESET   = 7'd20;
  localparam logic [TONE_W-1:0] TONE_MAX   = 4'd9;
  localparam int                TONE_STEP  = 25;
  localparam logic [CS_W-1:0]   ODD_SHIFT  = 7'd8;
  localparam logic [PIX_W-1:0]  ALPHA_FULL = 8'hFF;

  // reciprocal constants, exact over the value ranges in use
  localparam int DIV3_MUL   = 683;  // x*683 >> 11 == x/3 for x < 766
  localparam int DIV10_MUL  = 205;  // x*205 >> 11 == x/10 for x < 128
  localparam int RECIP_SHIFT = 11;

  // sequencer counts
  localparam logic [CNT_W-1:0] TONE_CNT_LAST = 4'd8;  // nine threshold steps
  localparam logic [CNT_W-1:0] MOD_CNT_TOP   = 4'd6;  // seven shift-subtract steps

  typedef struct packed {
    logic               action;
    logic [PIX_W-1:0]   red;
    logic [PIX_W-1:0]   green;
    logic [PIX_W-1:0]   blue;
    logic [COORD_W-1:0] col_in_cell;
    logic [COORD_W-1:0] row_in_cell;
    logic               odd_cell_row;
  } pix_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_blue;
    logic [PIX_W-1:0] out_green;
    logic [PIX_W-1:0] out_red;
    logic [PIX_W-1:0] out_alpha;
  } res_t;

  typedef struct packed {
    logic       load;       // input beat taken this cycle
    logic       tone_sq;    // square the cell size
    logic       tone_step;  // scale to the threshold step, clear tone
    logic       tone_cmp;   // one threshold compare
    logic       tone_done;  // last compare, clear the sum
    logic       mod_step;   // one shift-subtract step of the column reduction
    logic [2:0] mod_shift;
    logic       sq;         // distance and radius squares
    logic       out_load;   // capture the result beat
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_action;
    logic in_last;
  } dp_status_t;

endpackage

FILE: hdl/hdcf_ifs.sv
// hdcf_ifs: valid/ready channel interfaces for pixels, results and configuration
// depends on hdcf_pkg
interface hdcf_pix_if import hdcf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               action;
  logic [PIX_W-1:0]   red;
  logic [PIX_W-1:0]   green;
  logic [PIX_W-1:0]   blue;
  logic [COORD_W-1:0] col_in_cell;
  logic [COORD_W-1:0] row_in_cell;
  logic               odd_cell_row;

  modport source (output valid, action, red, green, blue, col_in_cell, row_in_cell,
                  odd_cell_row, input ready);
  modport sink (input valid, action, red, green, blue, col_in_cell, row_in_cell,
                odd_cell_row, output ready);
endinterface

interface hdcf_res_if import hdcf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] out_blue;
  logic [PIX_W-1:0] out_green;
  logic [PIX_W-1:0] out_red;
  logic [PIX_W-1:0] out_alpha;

  modport source (output valid, out_blue, out_green, out_red, out_alpha, input ready);
  modport sink (input valid, out_blue, out_green, out_red, out_alpha, output ready);
endinterface

interface hdcf_cfg_if import hdcf_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CS_W-1:0] cell_size;

  modport source (output valid, cell_size, input ready);
  modport sink (input valid, cell_size, output ready);
endinterface

FILE: hdl/hdcf_ctrl.sv
// hdcf_ctrl: sequencer for accumulate, tone and apply phases
// depends on hdcf_pkg; drives the datapath through ctrl_cmd_t
module hdcf_ctrl
  import hdcf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TONE_SQ,
    S_TONE_STEP,
    S_TONE_CMP,
    S_MOD,
    S_SQ,
    S_OUT
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;
  logic             accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd           = '0;
    cmd.load      = accept;
    cmd.tone_sq   = (state == S_TONE_SQ);
    cmd.tone_step = (state == S_TONE_STEP);
    cmd.tone_cmp  = (state == S_TONE_CMP);
    cmd.tone_done = (state == S_TONE_CMP) && (cnt == TONE_CNT_LAST);
    cmd.mod_step  = (state == S_MOD);
    cmd.mod_shift = cnt[2:0];
    cmd.sq        = (state == S_SQ);
    cmd.out_load  = (state == S_OUT) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (status.in_action) begin
              state <= S_MOD;
              cnt   <= MOD_CNT_TOP;
            end else if (status.in_last) begin
              state <= S_TONE_SQ;
            end
          end
        end
        S_TONE_SQ: state <= S_TONE_STEP;
        S_TONE_STEP: begin
          state <= S_TONE_CMP;
          cnt   <= '0;
        end
        S_TONE_CMP: begin
          if (cnt == TONE_CNT_LAST) begin
            state <= S_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_MOD: begin
          if (cnt == '0) begin
            state <= S_SQ;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_SQ: state <= S_OUT;
        S_OUT: begin
          if (cmd.out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/hdcf_datapath.sv
// hdcf_datapath: brightness sum, tone thresholds, column reduction and dot test
// depends on hdcf_pkg; sequenced by hdcf_ctrl
module hdcf_datapath
  import hdcf_pkg::*;
#(
  parameter int MAX_CELL_SIZE = MAX_CELL_SIZE_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [CS_W-1:0] cfg_data,
  input  pix_t            pix,
  input  ctrl_cmd_t       cmd,
  output dp_status_t      status,
  output res_t            res
);

  localparam int CS_CAP = (MAX_CELL_SIZE > (2**CS_W - 1)) ? (2**CS_W - 1) : MAX_CELL_SIZE;
  localparam int SQ_W   = 2 * CS_W;
  localparam int STEP_W = SQ_W + 5;
  localparam int THR_W  = STEP_W + 3;
  localparam int DIV_W  = CS_W + 6;
  localparam int D2_W   = 13;
  localparam int R_W    = CS_W - 1;

  logic [CS_W-1:0]    cell_size;
  logic [CS_W-1:0]    cs;
  logic [SUM_W-1:0]   sum;
  logic [TONE_W-1:0]  tone;

  // accumulate
  logic [9:0]         rgb_sum;
  logic [18:0]        div3_prod;
  logic [PIX_W-1:0]   gray;

  // tone thresholds
  logic [SQ_W-1:0]    sq;
  logic [STEP_W-1:0]  step;
  logic [THR_W-1:0]   thr;
  logic [THR_W-1:0]   thr_next;

  // apply
  logic [PIX_W-1:0]   red, green, blue;
  logic [COORD_W-1:0] row;
  logic [CS_W-1:0]    rem;
  logic [DIV_W-1:0]   divisor;
  logic [17:0]        div10_prod;
  logic [3:0]         tenth;
  logic [CS_W-1:0]    shrink;
  logic [R_W-1:0]     rad;
  logic [R_W-1:0]     half;
  logic signed [7:0]  dc, dr;
  logic signed [15:0] dc2, dr2;
  logic [D2_W-1:0]    d2;
  logic [D2_W-2:0]    r2;
  logic               in_dot;
  logic [PIX_W-1:0]   out_blue, out_green, out_red;

  // effective cell size: zero acts as one, large values clamp
  always_comb begin
    if (cell_size == '0) begin
      cs = CS_W'(1);
    end else if (cell_size > CS_W'(CS_CAP)) begin
      cs = CS_W'(CS_CAP);
    end else begin
      cs = cell_size;
    end
  end

  assign status.in_action = pix.action;
  assign status.in_last   = ({1'b0, pix.col_in_cell} == cs - 1'b1) &&
                            ({1'b0, pix.row_in_cell} == cs - 1'b1);

  assign rgb_sum   = {2'b0, pix.red} + {2'b0, pix.green} + {2'b0, pix.blue};
  assign div3_prod = 19'({9'b0, rgb_sum} * 19'(DIV3_MUL));
  assign gray      = div3_prod[RECIP_SHIFT +: PIX_W];

  assign thr_next  = thr + {3'b0, step};
  assign divisor   = {6'b0, cs} << cmd.mod_shift;
  assign half      = cs[CS_W-1:1];

  assign div10_prod = 18'({11'b0, cs} * 18'(DIV10_MUL));

  assign dc     = $signed({1'b0, rem}) - $signed({2'b0, half});
  assign dr     = $signed({2'b0, row}) - $signed({2'b0, half});
  assign dc2    = dc * dc;
  assign dr2    = dr * dr;
  assign in_dot = d2 <= {1'b0, r2};

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_size <= CS_RESET;
      sum       <= '0;
      tone      <= '0;
    end else begin
      if (cfg_we) begin
        cell_size <= cfg_data;
      end
      if (cmd.load && !pix.action) begin
        sum <= sum + {{(SUM_W-PIX_W){1'b0}}, gray};
      end else if (cmd.tone_done) begin
        sum <= '0;
      end
      if (cmd.tone_step) begin
        tone <= '0;
      end else if (cmd.tone_cmp && ({2'b0, sum} >= thr_next)) begin
        tone <= tone + 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.tone_sq) begin
      sq <= cs * cs;
    end
    if (cmd.tone_step) begin
      step <= STEP_W'({5'b0, sq} * STEP_W'(TONE_STEP));
      thr  <= '0;
    end else if (cmd.tone_cmp) begin
      thr <= thr_next;
    end

    if (cmd.load) begin
      red   <= pix.red;
      green <= pix.green;
      blue  <= pix.blue;
      row   <= pix.row_in_cell;
      rem   <= {1'b0, pix.col_in_cell} + (pix.odd_cell_row ? ODD_SHIFT : '0);
    end else if (cmd.mod_step && ({6'b0, rem} >= divisor)) begin
      rem <= rem - divisor[CS_W-1:0];
    end

    // radius chain settles within the reduction steps
    tenth  <= div10_prod[RECIP_SHIFT +: 4];
    shrink <= CS_W'({3'b0, tone} * {3'b0, tenth});
    rad    <= R_W'((cs - shrink) >> 1);

    if (cmd.sq) begin
      d2 <= dc2[D2_W-1:0] + dr2[D2_W-1:0];
      r2 <= (D2_W-1)'({6'b0, rad} * {6'b0, rad});
    end

    if (cmd.out_load) begin
      out_blue  <= in_dot ? '0 : blue;
      out_green <= in_dot ? '0 : green;
      out_red   <= in_dot ? '0 : red;
    end
  end

  assign res.out_blue  = out_blue;
  assign res.out_green = out_green;
  assign res.out_red   = out_red;
  assign res.out_alpha = ALPHA_FULL;

endmodule

FILE: hdl/halftone_dot_cell_filter_core.sv
// halftone_dot_cell_filter_core: top level of the halftone dot cell filter
// depends on hdcf_pkg, hdcf_ifs, hdcf_ctrl and hdcf_datapath
//
// channel  modport  beat carries
// pix      sink     action, red, green, blue, col_in_cell, row_in_cell, odd_cell_row
// res      source   out_blue, out_green, out_red, out_alpha (apply beats only)
// cfg      sink     cell_size, always ready
//
// one pixel is worked on at a time; pix.ready is high only while the sequencer idles
// accumulate beat: stays idle, or on the cell's last pixel runs nine threshold compares
// apply beat: the seven-step shift-subtract column reduction, then squares and output
// res holds its beat in an output register; a stalled res only stalls the final step
// rst is synchronous, active high: cell_size back to 20, sum and tone cleared
module halftone_dot_cell_filter_core
  import hdcf_pkg::*;
#(
  parameter int MAX_CELL_SIZE = MAX_CELL_SIZE_DEF
) (
  input logic         clk,
  input logic         rst,
  hdcf_pix_if.sink    pix,
  hdcf_res_if.source  res,
  hdcf_cfg_if.sink    cfg
);

  pix_t       pix_data;
  res_t       res_data;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  // configuration writes are always accepted and registered into cell_size
  assign cfg.ready = 1'b1;

  assign pix_data.action       = pix.action;
  assign pix_data.red          = pix.red;
  assign pix_data.green        = pix.green;
  assign pix_data.blue         = pix.blue;
  assign pix_data.col_in_cell  = pix.col_in_cell;
  assign pix_data.row_in_cell  = pix.row_in_cell;
  assign pix_data.odd_cell_row = pix.odd_cell_row;

  // sequencer: handshakes and phase stepping
  hdcf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pix.valid),
    .in_ready  (pix.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // arithmetic and result register
  hdcf_datapath #(
    .MAX_CELL_SIZE (MAX_CELL_SIZE)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg.valid && cfg.ready),
    .cfg_data (cfg.cell_size),
    .pix      (pix_data),
    .cmd      (cmd),
    .status   (status),
    .res      (res_data)
  );

  assign res.out_blue  = res_data.out_blue;
  assign res.out_green = res_data.out_green;
  assign res.out_red   = res_data.out_red;
  assign res.out_alpha = res_data.out_alpha;

endmodule

FILE: test/tb_halftone_dot_cell_filter_core.sv
`timescale 1ns / 1ps
// tb_halftone_dot_cell_filter_core: self-checking bench for the halftone dot cell filter core
// drives pix and cfg, checks res against a scoreboard class that predicts the dot mask
// depends on hdcf_pkg, hdcf_ifs and halftone_dot_cell_filter_core
module tb_halftone_dot_cell_filter_core;
  import hdcf_pkg::*;

  // pass select on the pixel channel
  localparam logic ACT_ACCUM = 1'b0;
  localparam logic ACT_APPLY = 1'b1;

  localparam int SETTLE_CYCLES = 32;      // covers the last-pixel accumulate and its tone steps
  localparam int HOLD_CYCLES   = 300;     // long res back-pressure stretch
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_BEATS  = 1500;

  // ---------------------------------------------------------------------------
  // scoreboard: shadow state of the filter plus the queue of masked pixels due
  // ---------------------------------------------------------------------------
  class dot_screen_scoreboard;
    logic [CS_W-1:0]   cell_side;
    logic [SUM_W-1:0]  luma_sum;
    logic [TONE_W-1:0] tone;
    res_t              masked_due[$];
    int                errors;

    function new();
      cell_side = CS_RESET;
      luma_sum  = '0;
      tone      = '0;
      errors    = 0;
    endfunction

    function void write_side(logic [CS_W-1:0] v);
      cell_side = v;
    endfunction

    // side in use: zero counts as one, oversize clamps to the build maximum
    function int unsigned side();
      int unsigned s;
      s = cell_side;
      if (s == 0) s = 1;
      if (s > MAX_CELL_SIZE_DEF) s = MAX_CELL_SIZE_DEF;
      return s;
    endfunction

    function int pending();
      return masked_due.size();
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("mismatch: %s", msg);
    endfunction

    // accepted pixel beat: accumulate updates the shadow state, apply queues a result
    function void take_pixel(pix_t p);
      int unsigned s, luma, lvl, rad, scol;
      int          ctr, dc, dr;
      res_t        r;
      s = side();
      if (p.action == ACT_ACCUM) begin
        luma     = (int'(p.red) + int'(p.green) + int'(p.blue)) / 3;
        luma_sum = SUM_W'(luma_sum + luma);
        if (p.col_in_cell == s - 1 && p.row_in_cell == s - 1) begin
          lvl      = luma_sum / (s * s) / TONE_STEP;
          tone     = (lvl > TONE_MAX) ? TONE_MAX : TONE_W'(lvl);
          luma_sum = '0;
        end
      end else begin
        ctr  = s / 2;
        rad  = (s - tone * (s / 10)) / 2;
        scol = (p.col_in_cell + (p.odd_cell_row ? int'(ODD_SHIFT) : 0)) % s;
        dc   = int'(scol) - ctr;
        dr   = int'(p.row_in_cell) - ctr;
        r.out_alpha = ALPHA_FULL;
        if (dc * dc + dr * dr <= int'(rad * rad)) begin
          r.out_blue  = '0;
          r.out_green = '0;
          r.out_red   = '0;
        end else begin
          r.out_blue  = p.blue;
          r.out_green = p.green;
          r.out_red   = p.red;
        end
        masked_due.push_back(r);
      end
    endfunction

    function void field_check(string name, logic [PIX_W-1:0] want, logic [PIX_W-1:0] got);
      if (got !== want) flag($sformatf("%s expected %0d got %0d", name, want, got));
    endfunction

    // accepted result beat: compare with the oldest masked pixel due
    function void check_beat(res_t got);
      res_t want;
      if (masked_due.size() == 0) begin
        flag($sformatf("result beat %h with nothing due", got));
      end else begin
        want = masked_due.pop_front();
        field_check("out_blue", want.out_blue, got.out_blue);
        field_check("out_green", want.out_green, got.out_green);
        field_check("out_red", want.out_red, got.out_red);
        field_check("out_alpha", want.out_alpha, got.out_alpha);
      end
    endfunction

    function void close_out();
      if (masked_due.size() != 0)
        flag($sformatf("%0d result beats never arrived", masked_due.size()));
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // block and channels
  // ---------------------------------------------------------------------------
  logic clk;
  logic rst;

  hdcf_pix_if pix ();
  hdcf_res_if res ();
  hdcf_cfg_if cfg ();

  halftone_dot_cell_filter_core dut (
    .clk (clk),
    .rst (rst),
    .pix (pix),
    .res (res),
    .cfg (cfg)
  );

  dot_screen_scoreboard sb = new();

  bit calm     = 1'b0;   // no idling on either side while set
  bit hold_req = 1'b0;   // asks the result side for one long stall
  int hold_left;
  int beats_sent = 0;
  int cycles = 0;

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run-away guard
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result side: check every accepted beat, then pick ready for the next edge
  initial begin
    res.ready <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && res.valid && res.ready)
        sb.check_beat({res.out_blue, res.out_green, res.out_red, res.out_alpha});
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= calm || ($urandom_range(0, 99) >= 6);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus tasks
  // ---------------------------------------------------------------------------

  // one pixel beat, with a random gap in front unless calm
  task automatic send_pixel(input logic act, input int r, input int g, input int b,
                            input int col, input int row, input logic odd);
    pix_t p;
    p.action       = act;
    p.red          = r[PIX_W-1:0];
    p.green        = g[PIX_W-1:0];
    p.blue         = b[PIX_W-1:0];
    p.col_in_cell  = col[COORD_W-1:0];
    p.row_in_cell  = row[COORD_W-1:0];
    p.odd_cell_row = odd;
    while (!calm && $urandom_range(0, 99) < 6) begin
      pix.valid <= 1'b0;
      @(posedge clk);
    end
    pix.valid        <= 1'b1;
    pix.action       <= p.action;
    pix.red          <= p.red;
    pix.green        <= p.green;
    pix.blue         <= p.blue;
    pix.col_in_cell  <= p.col_in_cell;
    pix.row_in_cell  <= p.row_in_cell;
    pix.odd_cell_row <= p.odd_cell_row;
    do @(posedge clk); while (!pix.ready);
    sb.take_pixel(p);
    beats_sent++;
  endtask

  // sender pauses until every result is in, then lets a last-pixel accumulate finish
  task automatic settle();
    pix.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // cell_size write, only with the block idle
  task automatic set_side(input int v);
    settle();
    cfg.cell_size <= v[CS_W-1:0];
    cfg.valid     <= 1'b1;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    sb.write_side(v[CS_W-1:0]);
  endtask

  // channel value near a cell's brightness level
  function automatic int shade(input int base, input int spread);
    int v;
    v = base + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v;
  endfunction

  // well-formed cell: raster accumulate pass, then raster apply pass
  task automatic full_pass(input int s, input logic odd, input bit stall_apply);
    int base, spread;
    base   = $urandom_range(0, 255);
    spread = $urandom_range(0, 40);
    for (int row = 0; row < s; row++)
      for (int col = 0; col < s; col++)
        send_pixel(ACT_ACCUM, shade(base, spread), shade(base, spread), shade(base, spread),
                   col, row, odd);
    // long result stall while the apply beats keep coming
    if (stall_apply) hold_req = 1'b1;
    for (int row = 0; row < s; row++)
      for (int col = 0; col < s; col++)
        send_pixel(ACT_APPLY, $urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 255), col, row, odd);
  endtask

  // large cells: a few beats only, apply with the carried tone first
  task automatic sparse_pass(input int s);
    int base;
    base = $urandom_range(0, 255);
    repeat (8)
      send_pixel(ACT_APPLY, $urandom_range(0, 255), $urandom_range(0, 255),
                 $urandom_range(0, 255), $urandom_range(0, s - 1), $urandom_range(0, s - 1),
                 $urandom_range(0, 1));
    // partial sum, never on the last pixel, then the last pixel itself
    repeat (30)
      send_pixel(ACT_ACCUM, shade(base, 20), shade(base, 20), shade(base, 20),
                 $urandom_range(0, s - 1), $urandom_range(0, s - 2), $urandom_range(0, 1));
    send_pixel(ACT_ACCUM, shade(base, 20), shade(base, 20), shade(base, 20), s - 1, s - 1, 1'b0);
    repeat (40)
      send_pixel(ACT_APPLY, $urandom_range(0, 255), $urandom_range(0, 255),
                 $urandom_range(0, 255), $urandom_range(0, s - 1), $urandom_range(0, s - 1),
                 $urandom_range(0, 1));
  endtask

  // anything goes: random pass, position over the full field range
  task automatic noise_burst(input int n);
    repeat (n)
      send_pixel($urandom_range(0, 1), $urandom_range(0, 255), $urandom_range(0, 255),
                 $urandom_range(0, 255), $urandom_range(0, 63), $urandom_range(0, 63),
                 $urandom_range(0, 1));
  endtask

  // edges of the fields and the odd corners of the behavior
  task automatic directed_run();
    // reset size 20, tone still zero: apply before any accumulate
    send_pixel(ACT_APPLY, 255, 255, 255, 10, 10, 1'b0);   // dead centre, blanked
    send_pixel(ACT_APPLY, 18, 52, 86, 0, 0, 1'b0);        // corner, passed
    send_pixel(ACT_APPLY, 129, 66, 33, 63, 63, 1'b1);     // outside the cell, column wraps
    send_pixel(ACT_APPLY, 200, 100, 50, 2, 10, 1'b1);     // odd-row shift lands in the dot
    send_pixel(ACT_ACCUM, 255, 255, 255, 63, 63, 1'b0);   // outside: summed, not the last pixel
    send_pixel(ACT_ACCUM, 255, 255, 255, 19, 19, 1'b0);   // last pixel of a nearly dark cell

    // smallest legal size, all white: tone saturates at nine
    set_side(2);
    send_pixel(ACT_ACCUM, 255, 255, 255, 0, 0, 1'b0);
    send_pixel(ACT_ACCUM, 255, 255, 255, 1, 0, 1'b0);
    send_pixel(ACT_ACCUM, 255, 255, 255, 0, 1, 1'b0);
    send_pixel(ACT_ACCUM, 255, 255, 255, 1, 1, 1'b0);
    send_pixel(ACT_APPLY, 0, 0, 0, 0, 0, 1'b0);
    send_pixel(ACT_APPLY, 255, 255, 255, 1, 1, 1'b1);
    send_pixel(ACT_APPLY, 90, 165, 240, 0, 1, 1'b1);
    send_pixel(ACT_APPLY, 15, 240, 170, 1, 0, 1'b0);

    // size zero behaves as one
    set_side(0);
    send_pixel(ACT_ACCUM, 0, 0, 0, 0, 0, 1'b0);
    send_pixel(ACT_APPLY, 77, 88, 99, 0, 0, 1'b1);
    send_pixel(ACT_APPLY, 170, 85, 204, 5, 3, 1'b0);

    // register maximum clamps to the largest cell
    set_side(127);
    send_pixel(ACT_APPLY, 1, 2, 3, 32, 32, 1'b0);
    send_pixel(ACT_APPLY, 254, 253, 252, 0, 40, 1'b1);
    send_pixel(ACT_ACCUM, 255, 255, 255, 63, 63, 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int first_random;
    int phase;
    int pick;
    int cs_val;
    int s;
    int odd_sizes[6];

    odd_sizes = '{0, 1, 2, 64, 65, 127};

    // every input known from time zero
    rst              <= 1'b1;
    pix.valid        <= 1'b0;
    pix.action       <= ACT_ACCUM;
    pix.red          <= '0;
    pix.green        <= '0;
    pix.blue         <= '0;
    pix.col_in_cell  <= '0;
    pix.row_in_cell  <= '0;
    pix.odd_cell_row <= 1'b0;
    cfg.valid        <= 1'b0;
    cfg.cell_size    <= CS_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    directed_run();

    // random part: mostly whole cells with a brightness level, some noise
    first_random = beats_sent;
    phase = 0;
    while (beats_sent - first_random < RANDOM_BEATS) begin
      pick = $urandom_range(0, 99);
      if (phase == 0)
        cs_val = 6;                            // hosts the long result stall
      else if (phase == 2)
        cs_val = $urandom_range(8, 12);        // idle-free stretch
      else if (pick < 70)
        cs_val = $urandom_range(2, 12);
      else if (pick < 84)
        cs_val = $urandom_range(13, 64);
      else if (pick < 92)
        cs_val = odd_sizes[$urandom_range(0, 5)];
      else
        cs_val = $urandom_range(65, 127);
      set_side(cs_val);
      calm = (phase == 2);
      s = sb.side();
      if (s <= 12) begin
        full_pass(s, $urandom_range(0, 1), phase == 0);
        repeat ($urandom_range(0, 2)) begin
          if ($urandom_range(0, 3) == 0) noise_burst($urandom_range(4, 16));
          full_pass(s, $urandom_range(0, 1), 1'b0);
        end
      end else begin
        sparse_pass(s);
      end
      if ($urandom_range(0, 2) == 0) noise_burst($urandom_range(4, 16));
      calm = 1'b0;
      phase++;
    end

    // drain and let the last accumulate finish
    settle();
    sb.close_out();
    if (sb.errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: files.f
hdl/hdcf_pkg.sv
hdl/hdcf_ifs.sv
hdl/hdcf_ctrl.sv
hdl/hdcf_datapath.sv
hdl/halftone_dot_cell_filter_core.sv
test/tb_halftone_dot_cell_filter_core.sv
